// File: rtl/assert_macros.svh
// assertion macros used by the rtl filter telnet_iac_filter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define AST_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tiac_pkg.sv
// package with telnet command codes, option codes, terminal character codes and filter state type
package tiac_pkg;

    localparam logic [7:0] C_NOP  = 8'd241;
    localparam logic [7:0] C_BRK  = 8'd243;
    localparam logic [7:0] C_IP   = 8'd244;
    localparam logic [7:0] C_EC   = 8'd247;
    localparam logic [7:0] C_EL   = 8'd248;
    localparam logic [7:0] C_WILL = 8'd251;
    localparam logic [7:0] C_WONT = 8'd252;
    localparam logic [7:0] C_DO   = 8'd253;
    localparam logic [7:0] C_DONT = 8'd254;
    localparam logic [7:0] C_IAC  = 8'd255;

    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_LOGOUT = 8'd18;

    localparam logic [7:0] CH_BRK = 8'h1C;
    localparam logic [7:0] CH_IP  = 8'h03;
    localparam logic [7:0] CH_EC  = 8'h08;
    localparam logic [7:0] CH_EL  = 8'h15;

    typedef enum logic [2:0] {
        P_IDLE,
        P_IAC,
        P_WILL,
        P_WONT,
        P_DO,
        P_DONT
    } t_pend;

endpackage

// File: rtl/tiac_if.sv
// valid/ready channel interfaces for received bytes and filter results
interface tiac_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tiac_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       to_peer;
    logic       last_of_run;
    logic       close_request;
    logic       echo_on;

    modport source (output valid, output out_byte, output to_peer, output last_of_run,
                    output close_request, output echo_on, input ready);
    modport sink   (input valid, input out_byte, input to_peer, input last_of_run,
                    input close_request, input echo_on, output ready);
endinterface

// File: rtl/telnet_iac_filter.sv
// telnet iac filter: decodes received bytes into terminal characters and peer replies
//
// channel  dir  beat content
// i_rx     in   rx_byte from the telnet peer
// o_tx     out  out_byte, to_peer, last_of_run, close_request, echo_on
//
// each received byte is decoded in the cycle it is taken and loaded into a
// three-byte result buffer; one result beat leaves per cycle while o_tx.ready is high
// a byte giving zero or one result is taken every cycle while o_tx.ready is
// high; a reply byte stalls i_rx, due to the single output port of the result buffer
// i_rx.ready is high while the buffer is empty or its last beat is being taken
// synchronous active-low reset clears the pending command, echo flag and buffer
`include "assert_macros.svh"

module telnet_iac_filter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tiac_rx_if.sink       i_rx,
    tiac_tx_if.source     o_tx
);
    import tiac_pkg::*;

    t_pend       r_pend, n_pend;
    logic        r_echo_flag, n_echo_flag;
    logic [1:0]  r_left, n_left;
    logic [7:0]  r_b0, r_b1, r_b2;
    logic        r_peer, r_close;

    logic [1:0]  d_cnt;
    logic [7:0]  d_b0, d_b1, d_b2;
    logic        d_peer, d_close;
    logic        w_acc, w_pop;

    assign i_rx.ready = (r_left == 2'd0) || ((r_left == 2'd1) && o_tx.ready);
    assign w_acc      = i_rx.valid && i_rx.ready;
    assign w_pop      = o_tx.valid && o_tx.ready;

    assign o_tx.valid         = (r_left != 2'd0);
    assign o_tx.out_byte      = r_b0;
    assign o_tx.to_peer       = r_peer;
    assign o_tx.last_of_run   = (r_left == 2'd1);
    assign o_tx.close_request = r_close;
    assign o_tx.echo_on       = r_echo_flag;

    // decode of one received byte
    always_comb begin
        n_pend      = P_IDLE;
        n_echo_flag = r_echo_flag;
        d_cnt       = 2'd0;
        d_b0        = i_rx.rx_byte;
        d_b1        = C_WILL;
        d_b2        = i_rx.rx_byte;
        d_peer      = 1'b0;
        d_close     = 1'b0;
        unique case (r_pend) inside
            P_IDLE: begin
                if (i_rx.rx_byte == C_IAC) begin
                    n_pend = P_IAC;
                end else begin
                    d_cnt = 2'd1;
                end
            end
            P_IAC: begin
                case (i_rx.rx_byte)
                    C_BRK: begin
                        d_cnt = 2'd1;
                        d_b0  = CH_BRK;
                    end
                    C_IP: begin
                        d_cnt = 2'd1;
                        d_b0  = CH_IP;
                    end
                    C_EC: begin
                        d_cnt = 2'd1;
                        d_b0  = CH_EC;
                    end
                    C_EL: begin
                        d_cnt = 2'd1;
                        d_b0  = CH_EL;
                    end
                    C_IAC: begin
                        d_cnt = 2'd1;
                    end
                    C_WILL: n_pend = P_WILL;
                    C_WONT: n_pend = P_WONT;
                    C_DO:   n_pend = P_DO;
                    C_DONT: n_pend = P_DONT;
                    default: n_pend = P_IDLE;
                endcase
            end
            P_WILL, P_DONT: begin
                if (i_rx.rx_byte == OPT_ECHO) begin
                    n_echo_flag = 1'b0;
                    d_cnt       = 2'd3;
                    d_b1        = C_WONT;
                end
            end
            P_WONT: begin
                d_cnt = 2'd0;
            end
            P_DO: begin
                d_cnt = 2'd3;
                case (i_rx.rx_byte)
                    OPT_ECHO:   n_echo_flag = 1'b1;
                    OPT_SGA:    d_b1 = C_WILL;
                    OPT_LOGOUT: d_close = 1'b1;
                    default:    d_b1 = C_WONT;
                endcase
            end
            default: begin
                d_cnt = 2'd0;
            end
        endcase
        // replies always open with iac
        if (d_cnt == 2'd3) begin
            d_b0   = C_IAC;
            d_peer = 1'b1;
        end
    end

    always_comb begin
        n_left = r_left;
        if (w_acc) begin
            n_left = d_cnt;
        end else if (w_pop) begin
            n_left = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= P_IDLE;
            r_echo_flag <= 1'b0;
            r_left      <= 2'd0;
        end else begin
            r_left <= n_left;
            if (w_acc) begin
                r_pend      <= n_pend;
                r_echo_flag <= n_echo_flag;
            end
        end
    end

    // result buffer, shifts one beat per pop
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_b0    <= d_b0;
            r_b1    <= d_b1;
            r_b2    <= d_b2;
            r_peer  <= d_peer;
            r_close <= d_close;
        end else if (w_pop) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

    `AST_ALWAYS(a_close_is_reply, !o_tx.valid || !o_tx.close_request || o_tx.to_peer,
        "close request on a terminal beat")
    `AST_ALWAYS(a_reply_opens_iac, !(o_tx.valid && (r_left == 2'd3)) || (o_tx.out_byte == C_IAC),
        "reply does not start with iac")
    `AST_NEXT(a_stall_holds, o_tx.valid && !o_tx.ready, $stable(r_left) && $stable(r_b0),
        "result buffer moved during stall")
    `AST_NEXT(a_iac_silent, w_acc && (r_pend == P_IDLE) && (i_rx.rx_byte == C_IAC),
        !o_tx.valid && (r_pend == P_IAC), "lone iac produced a beat")
    `AST_NEXT(a_echo_only_on_accept, !w_acc, $stable(r_echo_flag),
        "echo flag changed without a received byte")

endmodule
